// File: rtl/core/skt_pkg.sv
// Shared types and constants of the sorted key table.
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;

   // Raw key as it arrives on the request channel
   localparam int RAW_KEY_BYTES = 19;
   localparam int RAW_KEY_W     = 8 * RAW_KEY_BYTES;
   localparam int ENTRY_COUNT_W = 7;

   // Operation codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] key_hi;
      logic [63:0] key_mid;
      logic [23:0] key_lo;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic                     status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: rtl/core/skt_key_norm.sv
// Key normalizer: zero every byte from the first zero byte on and keep the leading KEY_BYTES bytes.
`timescale 1ns / 1ps
`default_nettype none
module skt_key_norm #(
   parameter int KEY_BYTES = 19
) (
   input  wire skt_pkg::req_type    req,
   output logic [8*KEY_BYTES-1:0]   key
);
   import skt_pkg::*;

   logic [RAW_KEY_W-1:0] raw;
   logic [RAW_KEY_W-1:0] clean;

   assign raw = {req.key_hi, req.key_mid, req.key_lo};

   // Mark the string end and clear every byte after it
   always_comb begin
      logic ended;
      ended = 1'b0;
      clean = '0;
      for (int i = 0; i < RAW_KEY_BYTES; i++) begin
         if (raw[RAW_KEY_W-1-8*i -: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            clean[RAW_KEY_W-1-8*i -: 8] = raw[RAW_KEY_W-1-8*i -: 8];
         end
      end
   end

   // Keep the leading KEY_BYTES bytes
   assign key = clean[RAW_KEY_W-1 -: 8*KEY_BYTES];

endmodule
`default_nettype wire

// File: rtl/core/skt_cell.sv
// One table cell: holds a key, compares it with the request key, shifts on insert.
`timescale 1ns / 1ps
`default_nettype none
module skt_cell #(
   parameter int KEY_W = 152,
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  wire                      clock,
   input  wire skt_pkg::cell_ctl_type ctl,
   input  wire  [CNT_W-1:0]         count,
   input  wire  [KEY_W-1:0]         cmp_key,
   input  wire  [KEY_W-1:0]         new_key,
   input  wire  [KEY_W-1:0]         prev_key,
   input  wire                      prev_gt,
   output logic [KEY_W-1:0]         key_out,
   output logic                     gt_out,
   output logic                     eq_out
);
   import skt_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             gt_ff;
   logic             gt_in;
   logic             eq_ff;
   logic             eq_in;
   logic             occupied;
   logic             at_end;
   logic             move;

   assign occupied = (CNT_W'(IDX) < count);
   assign at_end   = (CNT_W'(IDX) == count);

   // Compare stored key against the request key at transfer
   assign gt_in = occupied && (key_ff > cmp_key);
   assign eq_in = occupied && (key_ff == cmp_key);

   // Shift up when the stored key is larger, or take the free slot at the end
   assign move = (occupied && gt_ff) || at_end;

   always_comb begin
      key_in = key_ff;
      if (ctl.ins_en && move) begin
         key_in = prev_gt ? prev_key : new_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctl.cmp_en) begin
         gt_ff <= gt_in;
         eq_ff <= eq_in;
      end
   end

   assign key_out = key_ff;
   assign gt_out  = gt_ff;
   assign eq_out  = eq_ff;

endmodule
`default_nettype wire

// File: rtl/core/sorted_key_table_insert_search_unit.sv
// Top level of the sorted key table: request/response control and the cell chain.
//
// Keeps up to DEPTH keys of KEY_BYTES bytes in ascending byte order in a row
// of cells, one key per cell. A request carries a command (insert or lookup)
// and a key; every request yields exactly one response with found, status
// and the entry count after the operation. An insert into a full table
// stores nothing and returns the full status.
// Both channels move a transfer when valid is high and stall is low.
// Sequence: the transfer edge registers every cell's compare result; the
// commit edge shifts the cells (insert) or reduces the match flags (lookup)
// and loads the response register, which raises rsp_valid. req_stall is
// high from the transfer until that commit, so the block takes no new
// request before the compare and commit of the last one are done.
// A new request is taken while an earlier response still waits; the commit
// of that request holds until the response register frees up.
// Reset clears the entry count and all control state; cell contents are
// undefined and never read until written.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_insert_search_unit #(
   parameter int DEPTH     = 64,
   parameter int KEY_BYTES = 19
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire skt_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output skt_pkg::rsp_type    rsp_data
);
   import skt_pkg::*;

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [KEY_W-1:0] norm_key;
   logic             req_xfer;
   logic             commit;
   logic             full;
   logic             any_eq;
   cell_ctl_type     ctl;

   logic [KEY_W-1:0] key_link [DEPTH];
   logic [DEPTH-1:0] gt_link;
   logic [DEPTH-1:0] eq_link;

   // Normalize the incoming key
   skt_key_norm #(
      .KEY_BYTES (KEY_BYTES)
   ) u_norm (
      .req (req_data),
      .key (norm_key)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign commit    = (state_ff == ST_BUSY) && (!rsp_valid_ff || !rsp_stall);
   assign full      = (count_ff == CNT_W'(DEPTH));

   assign ctl.cmp_en = req_xfer;
   assign ctl.ins_en = commit && (cmd_ff == CMD_INSERT) && !full;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         skt_cell #(
            .KEY_W (KEY_W),
            .CNT_W (CNT_W),
            .IDX   (i)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .count    (count_ff),
            .cmp_key  (norm_key),
            .new_key  (key_ff),
            .prev_key (key_ff),
            .prev_gt  (1'b0),
            .key_out  (key_link[i]),
            .gt_out   (gt_link[i]),
            .eq_out   (eq_link[i])
         );
      end else begin : g_next
         skt_cell #(
            .KEY_W (KEY_W),
            .CNT_W (CNT_W),
            .IDX   (i)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .count    (count_ff),
            .cmp_key  (norm_key),
            .new_key  (key_ff),
            .prev_key (key_link[i-1]),
            .prev_gt  (gt_link[i-1]),
            .key_out  (key_link[i]),
            .gt_out   (gt_link[i]),
            .eq_out   (eq_link[i])
         );
      end
   end

   assign any_eq = |eq_link;

   // Next state, count and response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.found  = 1'b0;
               rsp_in.status = STATUS_DONE;
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_in.found = any_eq;
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               rsp_in.entry_count = ENTRY_COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_xfer) begin
         cmd_ff <= req_data.cmd;
         key_ff <= norm_key;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Entry count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table size");

   // An accepted insert into a non-full table adds exactly one entry
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.ins_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add one entry");

   // A lookup leaves the entry count alone
   a_lookup_keeps: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == CMD_LOOKUP) |=> $stable(count_ff))
      else $error("lookup changed entry count");

   // A full status only comes with a full table and never with a match
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |-> (full && !rsp_ff.found))
      else $error("full status on a table with room");

endmodule
`default_nettype wire
